// ===== rtl/hbm_pkg.sv =====
`timescale 1ns / 1ps
package hbm_pkg;

  localparam int SLOTS = 64;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;

  // operation codes
  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_DUPLICATE = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic start;   // latch a new operation and restart the scan
    logic adv;     // advance the scan pipeline by one slot
    logic finish;  // load the final result and commit any update
  } hbm_cmd_t;

  typedef struct packed {
    logic need_out;  // compare stage holds a match that pushes out an earlier one
    logic scan_end;  // compare stage holds the last slot of the scan
    logic out_free;  // output register can take a result this cycle
  } hbm_stat_t;

endpackage

// ===== rtl/hash_bucket_multimap_store.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake              Payload
// in_      input      in_valid / in_ready    in_kind, in_key, in_value
// out_     output     out_valid / out_ready  out_status, out_found_value, out_last,
//                                            out_live_count, out_is_full, out_is_empty
//
// One operation at a time: it is accepted, its slots are scanned through the read
// pipeline, and it is finished; the single read port of the slot memories sets the
// one-slot-per-cycle scan, except while a lookup stall, described below, holds it.
// Synchronous active-low reset clears the marks, the live count and all control state;
// slot contents stay undefined until written and need no clearing pass.
// A lookup stalls its scan while a new match meets a pending one and the output register is busy.
module hash_bucket_multimap_store
  import hbm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_kind,
  input  logic [KEY_W-1:0]  in_key,
  input  logic [VAL_W-1:0]  in_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [VAL_W-1:0]  out_found_value,
  output logic              out_last,
  output logic [CNT_W-1:0]  out_live_count,
  output logic              out_is_full,
  output logic              out_is_empty
);

  hbm_cmd_t  cmd;
  hbm_stat_t stat;

  // sequence the accept, scan and finish phases
  hbm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // hold the slots, run the scan and drive the result register
  hbm_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_kind         (in_kind),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_found_value (out_found_value),
    .out_last        (out_last),
    .out_live_count  (out_live_count),
    .out_is_full     (out_is_full),
    .out_is_empty    (out_is_empty)
  );

endmodule

// ===== rtl/hbm_ctrl.sv =====
`timescale 1ns / 1ps
module hbm_ctrl
  import hbm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  hbm_stat_t stat,
  output hbm_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cmd.start  = 1'b0;
    cmd.adv    = 1'b0;
    cmd.finish = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // stall while an earlier match cannot leave
        cmd.adv = !(stat.need_out && !stat.out_free);
        if (cmd.adv && stat.scan_end) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/hbm_dp.sv =====
`timescale 1ns / 1ps
module hbm_dp
  import hbm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  hbm_cmd_t          cmd,
  output hbm_stat_t         stat,
  input  logic [1:0]        in_kind,
  input  logic [KEY_W-1:0]  in_key,
  input  logic [VAL_W-1:0]  in_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [VAL_W-1:0]  out_found_value,
  output logic              out_last,
  output logic [CNT_W-1:0]  out_live_count,
  output logic              out_is_full,
  output logic              out_is_empty
);

  // slot storage
  logic [KEY_W-1:0] key_mem [SLOTS];
  logic [VAL_W-1:0] val_mem [SLOTS];
  logic [SLOTS-1:0] used_r;
  logic [SLOTS-1:0] live_r;
  logic [CNT_W-1:0] total_r;

  // latched operation
  logic [1:0]       op_kind_r;
  logic [KEY_W-1:0] op_key_r;
  logic [VAL_W-1:0] op_val_r;

  // issue stage
  logic             iss_act_r;
  logic [IDX_W-1:0] iss_idx_r;
  logic             iss_final;

  // compare stage
  logic             cmp_vld_r;
  logic             cmp_live_r;
  logic             cmp_last_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic [KEY_W-1:0] key_rd_r;
  logic [VAL_W-1:0] val_rd_r;

  // scan findings
  logic             pend_vld_r;
  logic [VAL_W-1:0] pend_val_r;
  logic             hit_r;
  logic [IDX_W-1:0] hit_idx_r;
  logic             free_vld_r;
  logic [IDX_W-1:0] free_idx_r;

  // output register
  logic             out_vld_r;
  logic [1:0]       out_status_r;
  logic [VAL_W-1:0] out_fv_r;
  logic             out_last_r;
  logic [CNT_W-1:0] out_cnt_r;

  logic             rd_en;
  logic             cmp_step;
  logic             key_hit;
  logic             pair_hit;
  logic             look_hit;
  logic             emit_pend;
  logic             full_now;
  logic             do_ins;
  logic             do_rem;
  logic [1:0]       fin_status;
  logic [VAL_W-1:0] fin_value;
  logic [CNT_W-1:0] fin_total;

  assign iss_final = !used_r[iss_idx_r] || (iss_idx_r == IDX_W'(SLOTS - 1));
  assign rd_en     = cmd.adv && iss_act_r;
  assign cmp_step  = cmd.adv && cmp_vld_r;
  assign key_hit   = cmp_live_r && (key_rd_r == op_key_r);
  assign pair_hit  = key_hit && (val_rd_r == op_val_r);
  assign look_hit  = cmp_vld_r && (op_kind_r == KIND_LOOKUP) && key_hit;
  assign emit_pend = cmd.adv && look_hit && pend_vld_r;

  assign stat.need_out = look_hit && pend_vld_r;
  assign stat.scan_end = cmp_vld_r && cmp_last_r;
  assign stat.out_free = !out_vld_r || out_ready;

  // final result and update decision
  assign full_now = (total_r == CNT_W'(SLOTS));

  always_comb begin
    fin_status = ST_NOT_FOUND;
    fin_value  = '0;
    do_ins     = 1'b0;
    do_rem     = 1'b0;
    case (op_kind_r)
      KIND_LOOKUP: begin
        if (pend_vld_r) begin
          fin_status = ST_OK;
          fin_value  = pend_val_r;
        end
      end
      KIND_INSERT: begin
        if (full_now) begin
          fin_status = ST_FULL;
        end else if (hit_r) begin
          fin_status = ST_DUPLICATE;
        end else if (free_vld_r) begin
          fin_status = ST_OK;
          do_ins     = 1'b1;
        end else begin
          fin_status = ST_FULL;
        end
      end
      KIND_REMOVE: begin
        if (hit_r) begin
          fin_status = ST_OK;
          do_rem     = 1'b1;
        end
      end
      default: begin
        fin_status = ST_NOT_FOUND;
      end
    endcase
  end

  assign fin_total = total_r + CNT_W'(do_ins) - CNT_W'(do_rem);

  // slot memories: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.finish && do_ins) begin
      key_mem[free_idx_r] <= op_key_r;
      val_mem[free_idx_r] <= op_val_r;
    end
    if (rd_en) begin
      key_rd_r <= key_mem[iss_idx_r];
      val_rd_r <= val_mem[iss_idx_r];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r     <= '0;
      live_r     <= '0;
      total_r    <= '0;
      iss_act_r  <= 1'b0;
      iss_idx_r  <= '0;
      cmp_vld_r  <= 1'b0;
      cmp_live_r <= 1'b0;
      cmp_last_r <= 1'b0;
      pend_vld_r <= 1'b0;
      hit_r      <= 1'b0;
      free_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (cmd.start) begin
        iss_act_r  <= 1'b1;
        iss_idx_r  <= '0;
        cmp_vld_r  <= 1'b0;
        pend_vld_r <= 1'b0;
        hit_r      <= 1'b0;
        free_vld_r <= 1'b0;
      end else if (cmd.adv) begin
        cmp_vld_r <= iss_act_r;
        if (iss_act_r) begin
          cmp_live_r <= live_r[iss_idx_r];
          cmp_last_r <= iss_final;
          iss_act_r  <= !iss_final;
          iss_idx_r  <= iss_idx_r + IDX_W'(1);
        end
        if (cmp_step) begin
          if (look_hit) begin
            pend_vld_r <= 1'b1;
          end
          if (pair_hit) begin
            hit_r <= 1'b1;
          end
          if (!cmp_live_r) begin
            free_vld_r <= 1'b1;
          end
        end
      end
      if (cmd.finish) begin
        total_r <= fin_total;
        if (do_ins) begin
          used_r[free_idx_r] <= 1'b1;
          live_r[free_idx_r] <= 1'b1;
        end
        if (do_rem) begin
          live_r[hit_idx_r] <= 1'b0;
        end
      end
      if (cmd.finish || emit_pend) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_kind_r <= in_kind;
      op_key_r  <= in_key;
      op_val_r  <= in_value;
    end
    if (cmd.adv && iss_act_r) begin
      cmp_idx_r <= iss_idx_r;
    end
    if (cmp_step) begin
      if (look_hit) begin
        pend_val_r <= val_rd_r;
      end
      if (pair_hit && !hit_r) begin
        hit_idx_r <= cmp_idx_r;
      end
      if (!cmp_live_r && !free_vld_r) begin
        free_idx_r <= cmp_idx_r;
      end
    end
    if (cmd.finish) begin
      out_status_r <= fin_status;
      out_fv_r     <= fin_value;
      out_last_r   <= 1'b1;
      out_cnt_r    <= fin_total;
    end else if (emit_pend) begin
      out_status_r <= ST_OK;
      out_fv_r     <= pend_val_r;
      out_last_r   <= 1'b0;
      out_cnt_r    <= total_r;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_status      = out_status_r;
  assign out_found_value = out_fv_r;
  assign out_last        = out_last_r;
  assign out_live_count  = out_cnt_r;
  assign out_is_full     = (out_cnt_r == CNT_W'(SLOTS));
  assign out_is_empty    = (out_cnt_r == '0);

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb
  import hbm_pkg::*;
();

  // Kind code that the block does not define; it must answer "not found".
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 12;
  localparam int HOLD_CYCLES  = 600;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_OPS   = 55;

  // One result transaction, in the order the ports list them.
  typedef struct packed {
    logic [1:0]       status;
    logic [VAL_W-1:0] found_value;
    logic             last;
    logic [CNT_W-1:0] live_count;
    logic             is_full;
    logic             is_empty;
  } bucket_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [1:0]       in_kind = KIND_LOOKUP;
  logic [KEY_W-1:0] in_key = '0;
  logic [VAL_W-1:0] in_value = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [1:0]       out_status;
  logic [VAL_W-1:0] out_found_value;
  logic             out_last;
  logic [CNT_W-1:0] out_live_count;
  logic             out_is_full;
  logic             out_is_empty;

  // Idle percentages for the two sides, and the long receiver hold-off flag.
  int   send_idle_pct = 21;
  int   recv_idle_pct = 45;
  logic hold_off = 1'b0;

  int err_count = 0;
  int cycle_count = 0;

  // Shadow copy of the bucket, kept in step with every accepted transaction.
  logic [KEY_W-1:0] bkt_key  [SLOTS];
  logic [VAL_W-1:0] bkt_val  [SLOTS];
  logic             bkt_used [SLOTS];
  logic             bkt_live [SLOTS];
  logic [CNT_W-1:0] bkt_count;

  // Results still owed by the block, oldest first.
  bucket_result_t due_results[$];

  hash_bucket_multimap_store uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_found_value (out_found_value),
    .out_last        (out_last),
    .out_live_count  (out_live_count),
    .out_is_full     (out_is_full),
    .out_is_empty    (out_is_empty)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Abort the run once the total cycle count reaches the limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("hash_bucket_multimap_store verification failed");
      $finish;
    end
  end

  // Receiver: drop ready at random, or hold it low for the whole hold-off stretch.
  always @(posedge clk) begin
    if (hold_off) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare every accepted result transaction against the oldest owed one.
  always @(posedge clk) begin : result_check
    bucket_result_t got;
    bucket_result_t want;
    if (rst_n && out_valid && out_ready) begin
      got.status      = out_status;
      got.found_value = out_found_value;
      got.last        = out_last;
      got.live_count  = out_live_count;
      got.is_full     = out_is_full;
      got.is_empty    = out_is_empty;
      if (due_results.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result: status=%0d value=%h last=%b count=%0d full=%b empty=%b",
                 $time, got.status, got.found_value, got.last, got.live_count,
                 got.is_full, got.is_empty);
      end else begin
        want = due_results.pop_front();
        if (got !== want) begin
          err_count++;
          $display("%0t: result mismatch", $time);
          $display("  expected status=%0d value=%h last=%b count=%0d full=%b empty=%b",
                   want.status, want.found_value, want.last, want.live_count,
                   want.is_full, want.is_empty);
          $display("  actual   status=%0d value=%h last=%b count=%0d full=%b empty=%b",
                   got.status, got.found_value, got.last, got.live_count,
                   got.is_full, got.is_empty);
        end
      end
    end
  end

  // Queue one owed result; the count and flags reflect the bucket after the operation.
  function automatic void owe_result(input logic [1:0] status, input logic [VAL_W-1:0] value,
                                     input logic last);
    bucket_result_t r;
    r.status      = status;
    r.found_value = value;
    r.last        = last;
    r.live_count  = bkt_count;
    r.is_full     = (bkt_count == CNT_W'(SLOTS));
    r.is_empty    = (bkt_count == '0);
    due_results   = {due_results, r};
  endfunction

  // Bounded scan: first live slot holding the exact pair, stopping after the
  // first slot that was never written. -1 when absent.
  function automatic int find_live_pair(input logic [KEY_W-1:0] key,
                                        input logic [VAL_W-1:0] val);
    for (int i = 0; i < SLOTS; i++) begin
      if (bkt_live[i] && bkt_key[i] == key && bkt_val[i] == val) return i;
      if (!bkt_used[i]) return -1;
    end
    return -1;
  endfunction

  // Apply one accepted operation to the shadow bucket and owe its results.
  function automatic void apply_bucket_op(input logic [1:0] kind, input logic [KEY_W-1:0] key,
                                          input logic [VAL_W-1:0] val);
    int               slot;
    bit               have_hit;
    logic [VAL_W-1:0] held_value;
    have_hit = 1'b0;
    held_value = '0;
    case (kind)
      KIND_LOOKUP: begin
        // Hold each hit back one step so that only the final one carries last.
        for (int i = 0; i < SLOTS; i++) begin
          if (bkt_live[i] && bkt_key[i] == key) begin
            if (have_hit) owe_result(ST_OK, held_value, 1'b0);
            have_hit = 1'b1;
            held_value = bkt_val[i];
          end
          if (!bkt_used[i]) break;
        end
        if (have_hit) owe_result(ST_OK, held_value, 1'b1);
        else owe_result(ST_NOT_FOUND, '0, 1'b1);
      end
      KIND_INSERT: begin
        // The full check wins over the duplicate check.
        if (bkt_count >= CNT_W'(SLOTS)) begin
          owe_result(ST_FULL, '0, 1'b1);
        end else if (find_live_pair(key, val) >= 0) begin
          owe_result(ST_DUPLICATE, '0, 1'b1);
        end else begin
          slot = 0;
          while (bkt_live[slot]) slot++;
          bkt_used[slot] = 1'b1;
          bkt_live[slot] = 1'b1;
          bkt_key[slot]  = key;
          bkt_val[slot]  = val;
          bkt_count++;
          owe_result(ST_OK, '0, 1'b1);
        end
      end
      KIND_REMOVE: begin
        // Leave a tombstone: clear live, keep used.
        slot = find_live_pair(key, val);
        if (slot >= 0) begin
          bkt_live[slot] = 1'b0;
          bkt_count--;
          owe_result(ST_OK, '0, 1'b1);
        end else begin
          owe_result(ST_NOT_FOUND, '0, 1'b1);
        end
      end
      default: owe_result(ST_NOT_FOUND, '0, 1'b1);
    endcase
  endfunction

  // Offer one operation, with a random gap first, and hold it until accepted.
  // Valid stays high afterwards so back-to-back transactions need not drop it in between.
  task automatic send_op(input logic [1:0] kind, input logic [KEY_W-1:0] key,
                         input logic [VAL_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_key   <= key;
    in_value <= val;
    do @(posedge clk); while (!in_ready);
    apply_bucket_op(kind, key, val);
  endtask

  // Drop valid, wait for every owed result, then let the scan pipeline empty.
  task automatic settle();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SLOTS + 8) @(posedge clk);
  endtask

  // Small key pool so that lookups, duplicates and removes hit often;
  // one pick in five is a full-width random key.
  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return 32'h0000_0001;
      3:       return 32'h8000_0000;
      4:       return 32'hA5A5_5A5A;
      5:       return 32'h7FFF_FFFF;
      6:       return 32'h1234_5678;
      7:       return 32'h0F0F_F0F0;
      default: return $urandom();
    endcase
  endfunction

  // Empty bucket: every kind but insert must miss cleanly.
  task automatic test_empty_bucket();
    send_op(KIND_LOOKUP, '0, '0);
    send_op(KIND_LOOKUP, '1, '1);
    send_op(KIND_REMOVE, '1, '0);
    send_op(KIND_UNUSED, '1, '1);
  endtask

  // Field extremes, duplicates, multi-hit lookups, tombstones and their reuse.
  task automatic test_basic_ops();
    send_op(KIND_INSERT, '0, '0);
    send_op(KIND_INSERT, '1, '1);
    send_op(KIND_INSERT, '0, '0);                 // exact pair again: duplicate
    send_op(KIND_INSERT, '0, 32'h0000_0005);      // same key, new value
    send_op(KIND_INSERT, 32'h0000_0007, 32'h8000_0001);
    send_op(KIND_LOOKUP, '0, '1);                 // two hits in slot order
    send_op(KIND_LOOKUP, '1, '0);
    send_op(KIND_REMOVE, '0, '0);                 // tombstone in slot zero
    send_op(KIND_LOOKUP, '0, '0);                 // scan must pass the tombstone
    send_op(KIND_REMOVE, '0, '0);                 // already gone
    send_op(KIND_REMOVE, 32'h0000_0007, 32'h8000_0002);
    send_op(KIND_INSERT, 32'h0000_0009, '1);      // reuses the tombstone
    send_op(KIND_LOOKUP, 32'h0000_0009, '0);
    send_op(KIND_UNUSED, 32'h0000_0007, 32'h8000_0001);
    send_op(KIND_LOOKUP, 32'h0000_0007, '0);
    send_op(KIND_LOOKUP, 32'h5555_AAAA, '0);      // miss over a populated bucket
  endtask

  // Fill every slot with one key, read all of them back, test both full refusals,
  // reuse one tombstone, then empty the bucket again.
  task automatic test_full_bucket();
    logic [KEY_W-1:0] fill_key;
    logic [VAL_W-1:0] fill_val [SLOTS];
    logic [31:0]      noise;
    int               victim;
    for (int i = 0; i < SLOTS; i++) begin
      if (bkt_live[i]) send_op(KIND_REMOVE, bkt_key[i], bkt_val[i]);
    end
    fill_key = $urandom();
    for (int i = 0; i < SLOTS; i++) begin
      noise = $urandom();
      fill_val[i] = {8'(i), noise[23:0]};
    end
    for (int i = 0; i < SLOTS; i++) send_op(KIND_INSERT, fill_key, fill_val[i]);
    send_op(KIND_LOOKUP, fill_key, '0);           // one result from every slot
    send_op(KIND_INSERT, fill_key, fill_val[3]);  // full beats duplicate
    send_op(KIND_INSERT, $urandom(), $urandom());
    send_op(KIND_LOOKUP, ~fill_key, '0);          // scan all slots, no hit
    victim = $urandom_range(SLOTS - 1);
    send_op(KIND_REMOVE, fill_key, fill_val[victim]);
    send_op(KIND_INSERT, ~fill_key, '1);
    send_op(KIND_LOOKUP, ~fill_key, '0);
    send_op(KIND_REMOVE, fill_key, fill_val[victim]);
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (i != victim) send_op(KIND_REMOVE, fill_key, fill_val[i]);
    end
    send_op(KIND_REMOVE, ~fill_key, '1);
    send_op(KIND_LOOKUP, fill_key, '0);
  endtask

  // Mixed traffic over a small key and value pool; most removes target
  // a pair that is present so tombstones pile up between live entries.
  task automatic test_random_traffic(input int ops);
    int               roll;
    int               ins_pct;
    int               slot;
    logic [1:0]       kind;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
    for (int n = 0; n < ops; n++) begin
      roll = $urandom_range(99);
      ins_pct = (bkt_count > CNT_W'(48)) ? 25 : 45;
      key = pick_key();
      val = ($urandom_range(9) == 0) ? VAL_W'($urandom()) : VAL_W'($urandom_range(3));
      if (roll < ins_pct) begin
        kind = KIND_INSERT;
      end else if (roll < 75) begin
        kind = KIND_REMOVE;
        if (bkt_count != '0 && $urandom_range(99) < 70) begin
          slot = $urandom_range(SLOTS - 1);
          while (!bkt_live[slot]) slot = (slot + 1) % SLOTS;
          key = bkt_key[slot];
          val = bkt_val[slot];
        end
      end else if (roll < 95) begin
        kind = KIND_LOOKUP;
      end else begin
        kind = KIND_UNUSED;
        val = $urandom();
      end
      send_op(kind, key, val);
    end
  endtask

  // Hold the receiver off for a long stretch while the sender keeps offering
  // transactions; the output register fills and the block must stall its input.
  task automatic test_output_backpressure();
    logic [KEY_W-1:0] busy_key;
    busy_key = $urandom();
    fork
      begin
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    for (int i = 0; i < 6; i++) send_op(KIND_INSERT, busy_key, VAL_W'(i));
    for (int i = 0; i < 6; i++) send_op(KIND_LOOKUP, busy_key, '0);
    send_op(KIND_INSERT, busy_key, VAL_W'(2));
    send_op(KIND_REMOVE, busy_key, VAL_W'(4));
    send_op(KIND_LOOKUP, busy_key, '0);
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      bkt_used[i] = 1'b0;
      bkt_live[i] = 1'b0;
    end
    bkt_count = '0;

    // Hold reset, then release it on a clock edge.
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Phase one: sender idles lightly, receiver heavily.
    send_idle_pct = 21;
    recv_idle_pct = 45;
    test_empty_bucket();
    settle();
    test_basic_ops();
    settle();
    test_random_traffic(RANDOM_OPS);
    settle();

    // Phase two: the other way round.
    send_idle_pct = 45;
    recv_idle_pct = 21;
    test_full_bucket();
    settle();
    test_random_traffic(RANDOM_OPS);
    settle();

    // Phase three: no idling on either side, plus the long hold-off.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_backpressure();
    settle();
    test_random_traffic(RANDOM_OPS);
    settle();

    if (err_count == 0) begin
      $display("hash_bucket_multimap_store verification clean");
    end else begin
      $display("hash_bucket_multimap_store verification failed");
    end
    $finish;
  end

endmodule
